// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is low
`define PLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, also checked during reset
`define PLP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/plp_pkg.sv =====
package plp_pkg;

    localparam int TABLE_POINTS = 13;
    localparam int ADC_BITS     = 10;
    localparam int PRES_BITS    = 10;
    localparam int IDX_BITS     = $clog2(TABLE_POINTS);
    localparam int PROD_BITS    = ADC_BITS + PRES_BITS;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

    localparam logic [PRES_BITS-1:0] TOP_PRES = PRES_BITS'(614);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [PRES_BITS-1:0] bp_pres(input logic [IDX_BITS-1:0] idx);
        logic [PRES_BITS-1:0] p;
        case (idx)
            4'd0:    p = 10'd0;
            4'd1:    p = 10'd39;
            4'd2:    p = 10'd50;
            4'd3:    p = 10'd79;
            4'd4:    p = 10'd107;
            4'd5:    p = 10'd141;
            4'd6:    p = 10'd177;
            4'd7:    p = 10'd217;
            4'd8:    p = 10'd265;
            4'd9:    p = 10'd427;
            4'd10:   p = 10'd494;
            4'd11:   p = 10'd577;
            4'd12:   p = 10'd614;
            default: p = 10'd0;
        endcase
        return p;
    endfunction

    function automatic logic [ADC_BITS-1:0] bp_code(input logic [IDX_BITS-1:0] idx);
        logic [ADC_BITS-1:0] c;
        case (idx)
            4'd0:    c = 10'd0;
            4'd1:    c = 10'd109;
            4'd2:    c = 10'd125;
            4'd3:    c = 10'd160;
            4'd4:    c = 10'd189;
            4'd5:    c = 10'd220;
            4'd6:    c = 10'd249;
            4'd7:    c = 10'd279;
            4'd8:    c = 10'd311;
            4'd9:    c = 10'd404;
            4'd10:   c = 10'd438;
            4'd11:   c = 10'd476;
            4'd12:   c = 10'd493;
            default: c = 10'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/plp_if.sv =====
interface plp_req_if;
    logic                          valid;
    logic                          ready;
    logic [plp_pkg::ADC_BITS-1:0]  adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface plp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [plp_pkg::PRES_BITS-1:0] pressure;
    logic                          saturated;

    modport source (output valid, output pressure, output saturated, input ready);
    modport sink   (input valid, input pressure, input saturated, output ready);
endinterface

// ===== design/plp_div.sv =====
module plp_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [plp_pkg::PROD_BITS-1:0]  dividend,
    input  logic [plp_pkg::ADC_BITS-1:0]   divisor,
    output logic                           done,
    output logic [plp_pkg::PROD_BITS-1:0]  quotient
);

    localparam int QW = plp_pkg::PROD_BITS;
    localparam int DW = plp_pkg::ADC_BITS;
    localparam int CW = plp_pkg::DIV_CNT_BITS;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg, dvs_next;

    logic [DW:0]   shifted;
    logic [DW+1:0] diff;
    logic          last;

    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign last    = (cnt_reg == CW'(QW - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // restoring step, one quotient bit
            if (!diff[DW+1])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/piecewise_linear_pressure_lookup_unit.sv =====
// a saturated sample goes from search straight to the done state and skips the multiply and divide
// search examines the breakpoints in order from index 1, then the multiply state starts the divider
// the restoring divider then produces 20 quotient bits and raises done
// a new request is taken only in the idle state, after the last result has entered the output register
// a stalled result holds the sequencer in its done state until the output register frees
// rst_n (async, active low) clears the sequencer and the result valid flag
module piecewise_linear_pressure_lookup_unit (
    input  logic      clk,
    input  logic      rst_n,
    plp_req_if.sink   req,
    plp_rsp_if.source rsp
);

    localparam int AW = plp_pkg::ADC_BITS;
    localparam int PW = plp_pkg::PRES_BITS;
    localparam int IW = plp_pkg::IDX_BITS;
    localparam int QW = plp_pkg::PROD_BITS;

    plp_pkg::state_t state_reg, state_next;

    logic [AW-1:0] sample_reg, sample_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [PW-1:0] lo_pres_reg, lo_pres_next;
    logic [PW-1:0] hi_pres_reg, hi_pres_next;
    logic [PW-1:0] rise_reg, rise_next;
    logic [AW-1:0] offset_reg, offset_next;
    logic [AW-1:0] span_reg, span_next;
    logic          sat_reg, sat_next;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_pres_reg, out_pres_next;
    logic          out_sat_reg, out_sat_next;

    logic [IW-1:0] idx_prev;
    logic [AW-1:0] cur_code;
    logic [AW-1:0] prev_code;
    logic          hit;
    logic          at_top;
    logic          out_free;
    logic          div_start;
    logic          div_done;
    logic [QW-1:0] product;
    logic [QW-1:0] quotient;
    logic [PW-1:0] interp;

    assign idx_prev  = idx_reg - IW'(1);
    assign cur_code  = plp_pkg::bp_code(idx_reg);
    assign prev_code = plp_pkg::bp_code(idx_prev);
    assign hit       = (sample_reg <= cur_code);
    assign at_top    = (idx_reg == IW'(plp_pkg::TABLE_POINTS - 1));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign product   = QW'(rise_reg) * QW'(offset_reg);
    assign interp    = (span_reg == '0) ? hi_pres_reg : lo_pres_reg + quotient[PW-1:0];

    plp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plp_pkg::ST_IDLE:
            begin
                if (req.valid)
                    state_next = plp_pkg::ST_SEARCH;
            end
            plp_pkg::ST_SEARCH:
            begin
                if (hit)
                    state_next = plp_pkg::ST_MUL;
                else if (at_top)
                    state_next = plp_pkg::ST_DONE;
            end
            plp_pkg::ST_MUL:
                state_next = plp_pkg::ST_DIV;
            plp_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = plp_pkg::ST_DONE;
            end
            plp_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = plp_pkg::ST_IDLE;
            end
            default:
                state_next = plp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req.ready = (state_reg == plp_pkg::ST_IDLE);
        div_start = (state_reg == plp_pkg::ST_MUL);
    end

    // datapath
    always_comb
    begin
        sample_next    = sample_reg;
        idx_next       = idx_reg;
        lo_pres_next   = lo_pres_reg;
        hi_pres_next   = hi_pres_reg;
        rise_next      = rise_reg;
        offset_next    = offset_reg;
        span_next      = span_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;
        out_pres_next  = out_pres_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            plp_pkg::ST_IDLE:
            begin
                sample_next = req.adc_sample;
                idx_next    = IW'(1);
                sat_next    = 1'b0;
            end
            plp_pkg::ST_SEARCH:
            begin
                if (hit)
                begin
                    lo_pres_next = plp_pkg::bp_pres(idx_prev);
                    hi_pres_next = plp_pkg::bp_pres(idx_reg);
                    rise_next    = plp_pkg::bp_pres(idx_reg) - plp_pkg::bp_pres(idx_prev);
                    offset_next  = sample_reg - prev_code;
                    span_next    = cur_code - prev_code;
                end
                else if (at_top)
                    sat_next = 1'b1;
                else
                    idx_next = idx_reg + IW'(1);
            end
            plp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sat_next   = sat_reg;
                    out_pres_next  = sat_reg ? plp_pkg::TOP_PRES : interp;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        idx_reg      <= idx_next;
        lo_pres_reg  <= lo_pres_next;
        hi_pres_reg  <= hi_pres_next;
        rise_reg     <= rise_next;
        offset_reg   <= offset_next;
        span_reg     <= span_next;
        sat_reg      <= sat_next;
        out_pres_reg <= out_pres_next;
        out_sat_reg  <= out_sat_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.pressure  = out_pres_reg;
    assign rsp.saturated = out_sat_reg;

endmodule

// ===== design/plp_checker.sv =====
`include "assert_macros.svh"

module plp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [plp_pkg::PRES_BITS-1:0] pressure,
    input logic                          saturated
);

    `PLP_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !rsp_valid, "result valid during reset")
    `PLP_ASSERT(a_sat_top, rsp_valid && saturated |-> pressure == plp_pkg::TOP_PRES, "saturated result is not the top pressure")
    `PLP_ASSERT(a_range, rsp_valid |-> pressure <= plp_pkg::TOP_PRES, "pressure above top breakpoint")
    `PLP_ASSERT(a_busy_after_req, req_valid && req_ready |=> !req_ready, "request taken while busy")
    `PLP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(pressure) && $stable(saturated), "stalled result changed")

endmodule

bind piecewise_linear_pressure_lookup_unit plp_checker u_plp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .pressure  (rsp.pressure),
    .saturated (rsp.saturated)
);

// ===== tb/plp_pressure_checker.sv =====
`timescale 1ns / 100ps

module plp_pressure_checker (
    input  logic clk,
    input  logic rst_n,
    plp_req_if   req,
    plp_rsp_if   rsp,
    output int   fail_count,
    output int   readings_in_flight
);

    typedef struct packed {
        logic [plp_pkg::PRES_BITS-1:0] pressure;
        logic                          saturated;
    } gauge_reading_t;

    typedef struct packed {
        logic [plp_pkg::PRES_BITS-1:0] pres;
        logic [plp_pkg::ADC_BITS-1:0]  code;
    } knee_t;

    gauge_reading_t awaited_readings[$];
    int             failures = 0;

    assign fail_count         = failures;
    assign readings_in_flight = awaited_readings.size();

    function automatic knee_t knee_point(input int idx);
        knee_t kp;
        case (idx)
            0:       kp = '{pres: 10'd0,   code: 10'd0};
            1:       kp = '{pres: 10'd39,  code: 10'd109};
            2:       kp = '{pres: 10'd50,  code: 10'd125};
            3:       kp = '{pres: 10'd79,  code: 10'd160};
            4:       kp = '{pres: 10'd107, code: 10'd189};
            5:       kp = '{pres: 10'd141, code: 10'd220};
            6:       kp = '{pres: 10'd177, code: 10'd249};
            7:       kp = '{pres: 10'd217, code: 10'd279};
            8:       kp = '{pres: 10'd265, code: 10'd311};
            9:       kp = '{pres: 10'd427, code: 10'd404};
            10:      kp = '{pres: 10'd494, code: 10'd438};
            11:      kp = '{pres: 10'd577, code: 10'd476};
            default: kp = '{pres: 10'd614, code: 10'd493};
        endcase
        return kp;
    endfunction

    function automatic gauge_reading_t interpolate_pressure(
        input logic [plp_pkg::ADC_BITS-1:0] sample);
        gauge_reading_t result;
        knee_t          lo;
        knee_t          hi;
        int unsigned    span;
        int unsigned    rise;
        result.pressure  = knee_point(plp_pkg::TABLE_POINTS - 1).pres;
        result.saturated = 1'b1;
        for (int k = 1; k < plp_pkg::TABLE_POINTS; k++)
        begin
            hi = knee_point(k);
            if (sample <= hi.code)
            begin
                lo   = knee_point(k - 1);
                span = hi.code - lo.code;
                rise = hi.pres - lo.pres;
                if (span == 0)
                    result.pressure = hi.pres;
                else
                    result.pressure = plp_pkg::PRES_BITS'(lo.pres
                                      + (rise * (sample - lo.code)) / span);
                result.saturated = 1'b0;
                break;
            end
        end
        return result;
    endfunction

    always @(posedge clk)
    begin
        gauge_reading_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                awaited_readings.push_back(interpolate_pressure(req.adc_sample));
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_readings.size() == 0)
                begin
                    $error("unexpected result: pressure %0d saturated %0d",
                           rsp.pressure, rsp.saturated);
                    failures++;
                end
                else
                begin
                    want = awaited_readings.pop_front();
                    if (rsp.pressure !== want.pressure)
                    begin
                        $error("pressure: expected %0d, actual %0d",
                               want.pressure, rsp.pressure);
                        failures++;
                    end
                    if (rsp.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0d, actual %0d",
                               want.saturated, rsp.saturated);
                        failures++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb_piecewise_linear_pressure_lookup_unit.sv =====
`timescale 1ns / 100ps

module tb_piecewise_linear_pressure_lookup_unit;

    localparam int RANDOM_READINGS = 1950;

    logic clk;
    logic rst_n;
    bit   send_idle_on = 1'b1;
    bit   recv_idle_on = 1'b1;
    int   fail_count;
    int   readings_in_flight;

    logic [plp_pkg::ADC_BITS-1:0] directed_readings[$] = '{
        10'd0, 10'd1, 10'd109, 10'd125, 10'd160, 10'd189, 10'd220, 10'd249,
        10'd279, 10'd311, 10'd404, 10'd438, 10'd476, 10'd493, 10'd492,
        10'd494, 10'd1023, 10'd512, 10'd108, 10'd110, 10'd682, 10'd341
    };

    plp_req_if req_ch ();
    plp_rsp_if rsp_ch ();

    piecewise_linear_pressure_lookup_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    plp_pressure_checker checker_inst (
        .clk                (clk),
        .rst_n              (rst_n),
        .req                (req_ch),
        .rsp                (rsp_ch),
        .fail_count         (fail_count),
        .readings_in_flight (readings_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= !(recv_idle_on && $urandom_range(99) < 23);
        end
    end

    function automatic logic [plp_pkg::ADC_BITS-1:0] pick_reading();
        int unsigned sel;
        int unsigned knee;
        sel = $urandom_range(99);
        if (sel < 60)
            return plp_pkg::ADC_BITS'($urandom_range(500, 0));
        if (sel < 80)
        begin
            knee = $urandom_range(plp_pkg::TABLE_POINTS - 1, 1);
            return plp_pkg::bp_code(plp_pkg::IDX_BITS'(knee))
                   + plp_pkg::ADC_BITS'($urandom_range(4)) - plp_pkg::ADC_BITS'(2);
        end
        return plp_pkg::ADC_BITS'($urandom_range(1023, 0));
    endfunction

    // called at a falling edge; ready only moves at rising edges
    task automatic send_reading(input logic [plp_pkg::ADC_BITS-1:0] sample);
        bit taken;
        while (send_idle_on && $urandom_range(99) < 23)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.adc_sample <= sample;
        do
        begin
            taken = req_ch.ready;
            @(negedge clk);
        end
        while (!taken);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.adc_sample = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_readings[i])
            send_reading(directed_readings[i]);

        for (int n = 0; n < RANDOM_READINGS; n++)
        begin
            if (n == 700)
            begin
                // drain the block before going on
                req_ch.valid <= 1'b0;
                @(negedge clk);
                while (readings_in_flight != 0)
                    @(negedge clk);
            end
            if (n == 900)
            begin
                send_idle_on = 1'b0;
                recv_idle_on = 1'b0;
            end
            if (n == 1300)
            begin
                send_idle_on = 1'b1;
                recv_idle_on = 1'b1;
            end
            send_reading(pick_reading());
        end

        req_ch.valid <= 1'b0;
        while (readings_in_flight != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
